[rtl/ptst_pkg.sv]
`default_nettype none
package ptst_pkg;

   localparam int KEY_BITS   = 64;
   localparam int TIN_BITS   = 40;
   localparam int QTY_BITS   = 32;
   localparam int PRICE_BITS = 32;
   localparam int SLOT_BITS  = 6;
   localparam int VOL_BITS   = 48;
   localparam int SUM_BITS   = 64;
   localparam int REQ_DATA_BITS = 176;
   localparam int RSP_DATA_BITS = 256;

   typedef enum logic [1:0] {
      STATUS_UPDATED  = 2'd0,
      STATUS_INSERTED = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_READ     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ENG_IDLE,
      ENG_MUL,
      ENG_SCAN,
      ENG_UPD,
      ENG_READ,
      ENG_RDATA
   } eng_state_type;

   // One queued item, already classified as a read or a trade.
   typedef struct packed {
      logic                  is_read;
      logic [KEY_BITS-1:0]   symbol_key;
      logic [TIN_BITS-1:0]   trade_time;
      logic [QTY_BITS-1:0]   quantity;
      logic [PRICE_BITS-1:0] price;
      logic [SLOT_BITS-1:0]  read_slot;
   } item_type;

   typedef struct packed {
      status_type            status;
      logic                  slot_valid;
      logic [KEY_BITS-1:0]   out_key;
      logic [TIN_BITS-1:0]   out_max_gap;
      logic [VOL_BITS-1:0]   out_volume;
      logic [SUM_BITS-1:0]   out_weighted_sum;
      logic [PRICE_BITS-1:0] out_max_price;
      logic [SLOT_BITS-1:0]  out_slot;
   } result_type;

endpackage
`default_nettype wire

[rtl/per_key_trade_stats_table_unit.sv]
// Per-symbol trade statistics table.
// The req_ channel carries one item per transfer. req_tuser selects the
// command: 0 applies a trade (key, time, quantity, price) and 1 reads the
// table slot given in read_slot. Every item gives exactly one rsp_ transfer,
// whose tuser holds the status (updated, inserted, full, read) and whose
// tdata holds the reported entry.
// A trade scans the valid slots in order, one key compare per cycle through
// the single read port of the table memory, so its time grows with fill,
// the number of occupied slots. A read goes straight to its slot.
// Items are handled one at a time by the table engine; a two-entry queue in
// front keeps taking transfers while the engine is busy or while a result
// waits in the output register.
// Reset empties the table at once (the fill count goes to zero) and clears
// the queue and the output register. When the receiver holds rsp_tready low
// the result stays in the output register, the engine waits, and the queue
// fills, after which req_tready drops.
`default_nettype none
module per_key_trade_stats_table_unit
   import ptst_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int TIME_BITS   = 40
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // symbol_key, trade_time, quantity, price, read_slot, zero padding
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // command
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // slot_valid, out_key, out_max_gap, out_volume, out_weighted_sum,
   // out_max_price, out_slot, zero padding
   output logic [RSP_DATA_BITS-1:0]      rsp_tdata,
   // status
   output logic [1:0]                    rsp_tuser
);

   item_type   item;
   logic       item_valid;
   logic       item_pop;
   result_type res;

   ptst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   ptst_engine #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .res_valid  (rsp_tvalid),
      .res        (res),
      .res_ready  (rsp_tready)
   );

   // Pack the result fields, slot_valid in the lowest bit, zero padding in the highest.
   assign rsp_tdata = {1'b0, res.out_slot, res.out_max_price, res.out_weighted_sum,
                       res.out_volume, res.out_max_gap, res.out_key, res.slot_valid};
   assign rsp_tuser = res.status;

endmodule
`default_nettype wire

[rtl/ptst_ram.sv]
`default_nettype none
module ptst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/ptst_front.sv]
`default_nettype none
module ptst_front
   import ptst_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   input  wire logic                     req_tuser,
   output logic                          item_valid,
   output item_type                      item,
   input  wire logic                     item_pop
);

   // Two-entry queue between the stream port and the table engine.
   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push;
   logic       pop;

   always_comb begin
      new_item.is_read    = req_tuser;
      new_item.symbol_key = req_tdata[63:0];
      new_item.trade_time = req_tdata[103:64];
      new_item.quantity   = req_tdata[135:104];
      new_item.price      = req_tdata[167:136];
      new_item.read_slot  = req_tdata[173:168];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (count_ff != 2'd0);
   assign pop        = item_pop && item_valid;
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

[rtl/ptst_engine.sv]
`default_nettype none
module ptst_engine
   import ptst_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int TIME_BITS   = 40
) (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  item_valid,
   input  item_type   item,
   output logic       item_pop,
   output logic       res_valid,
   output result_type res,
   input  wire logic  res_ready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int FW = $clog2(TABLE_DEPTH + 1);
   localparam int LW = AW + SLOT_BITS;
   localparam int TB = TIME_BITS;
   localparam int EW = KEY_BITS + 2 * TB + VOL_BITS + PRICE_BITS + SUM_BITS;
   localparam logic [VOL_BITS:0] VOL_MAX = {1'b0, {VOL_BITS{1'b1}}};

   typedef struct packed {
      logic [SUM_BITS-1:0]   wsum;
      logic [PRICE_BITS-1:0] max_price;
      logic [VOL_BITS-1:0]   volume;
      logic [TB-1:0]         max_gap;
      logic [TB-1:0]         prev_time;
      logic [KEY_BITS-1:0]   key;
   } entry_type;

   eng_state_type state_ff, state_in;
   item_type      it_ff;
   logic [TB-1:0] time_ff;
   logic [63:0]   prod_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] issue_ff, issue_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AW-1:0] chk_idx_ff;
   logic [AW-1:0] hit_idx_ff;
   entry_type     ent_ff;
   logic          rd_ok_ff;
   result_type    res_ff, res_in;
   logic          res_valid_ff, res_valid_in;

   logic [AW-1:0] rd_addr;
   logic [EW-1:0] rd_raw;
   entry_type     rd_ent;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_ent;
   logic          hit;
   logic          miss;
   logic          full;
   logic [LW-1:0] slot_ext;
   logic [LW-1:0] fill_ext;
   logic          slot_ok;
   logic [TB+TIN_BITS-1:0] time_ext;
   logic [TB+TIN_BITS-1:0] gap_ext;
   logic [TB-1:0]          gap;
   logic [VOL_BITS:0]      vol_sum;
   entry_type              upd_ent;

   assign rd_ent   = entry_type'(rd_raw);
   assign slot_ext = {{AW{1'b0}}, it_ff.read_slot};
   assign fill_ext = {{(LW-FW){1'b0}}, fill_ff};
   assign slot_ok  = slot_ext < fill_ext;
   assign time_ext = {{TB{1'b0}}, item.trade_time};
   assign full     = (fill_ff == FW'(TABLE_DEPTH));
   assign hit      = chk_vld_ff && (rd_ent.key == it_ff.symbol_key);
   assign miss     = !hit && (issue_ff == fill_ff);
   assign item_pop = (state_ff == ENG_IDLE) && item_valid && !res_valid_ff;

   // Updated entry for a hit.
   always_comb begin
      gap     = time_ff - ent_ff.prev_time;
      vol_sum = {1'b0, ent_ff.volume} + {{(VOL_BITS+1-QTY_BITS){1'b0}}, it_ff.quantity};
      upd_ent.key       = ent_ff.key;
      upd_ent.prev_time = time_ff;
      upd_ent.max_gap   = (gap > ent_ff.max_gap) ? gap : ent_ff.max_gap;
      upd_ent.volume    = (vol_sum > VOL_MAX) ? VOL_MAX[VOL_BITS-1:0]
                                              : vol_sum[VOL_BITS-1:0];
      upd_ent.max_price = (it_ff.price > ent_ff.max_price) ? it_ff.price
                                                           : ent_ff.max_price;
      upd_ent.wsum      = ent_ff.wsum + prod_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ENG_IDLE: begin
            if (item_pop) begin
               state_in = item.is_read ? ENG_READ : ENG_MUL;
            end
         end
         ENG_MUL:   state_in = ENG_SCAN;
         ENG_SCAN: begin
            if (hit) begin
               state_in = ENG_UPD;
            end else if (miss) begin
               state_in = ENG_IDLE;
            end
         end
         ENG_UPD:   state_in = ENG_IDLE;
         ENG_READ:  state_in = ENG_RDATA;
         ENG_RDATA: state_in = ENG_IDLE;
         default:   state_in = ENG_IDLE;
      endcase
   end

   // Outputs, memory access and counters.
   always_comb begin
      rd_addr      = issue_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = hit_idx_ff;
      wr_ent       = upd_ent;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      fill_in      = fill_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_ready;
      gap_ext      = {{TIN_BITS{1'b0}}, upd_ent.max_gap};
      case (state_ff)
         ENG_IDLE: begin
            issue_in = '0;
         end
         ENG_SCAN: begin
            if (!hit && (issue_ff != fill_ff)) begin
               issue_in   = issue_ff + FW'(1);
               chk_vld_in = 1'b1;
            end
            if (miss) begin
               res_valid_in = 1'b1;
               res_in       = '0;
               if (full) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  wr_en             = 1'b1;
                  wr_addr           = fill_ff[AW-1:0];
                  wr_ent.key        = it_ff.symbol_key;
                  wr_ent.prev_time  = time_ff;
                  wr_ent.max_gap    = '0;
                  wr_ent.volume     = {{(VOL_BITS-QTY_BITS){1'b0}}, it_ff.quantity};
                  wr_ent.max_price  = it_ff.price;
                  wr_ent.wsum       = prod_ff;
                  fill_in           = fill_ff + FW'(1);
                  res_in.status           = STATUS_INSERTED;
                  res_in.slot_valid       = 1'b1;
                  res_in.out_key          = it_ff.symbol_key;
                  res_in.out_volume       = wr_ent.volume;
                  res_in.out_weighted_sum = prod_ff;
                  res_in.out_max_price    = it_ff.price;
                  res_in.out_slot         = SLOT_BITS'(fill_ff);
               end
            end
         end
         ENG_UPD: begin
            wr_en                   = 1'b1;
            res_valid_in            = 1'b1;
            res_in.status           = STATUS_UPDATED;
            res_in.slot_valid       = 1'b1;
            res_in.out_key          = upd_ent.key;
            res_in.out_max_gap      = gap_ext[TIN_BITS-1:0];
            res_in.out_volume       = upd_ent.volume;
            res_in.out_weighted_sum = upd_ent.wsum;
            res_in.out_max_price    = upd_ent.max_price;
            res_in.out_slot         = SLOT_BITS'(hit_idx_ff);
         end
         ENG_READ: begin
            rd_addr = slot_ext[AW-1:0];
         end
         ENG_RDATA: begin
            gap_ext      = {{TIN_BITS{1'b0}}, rd_ent.max_gap};
            res_valid_in = 1'b1;
            res_in       = '0;
            res_in.status   = STATUS_READ;
            res_in.out_slot = it_ff.read_slot;
            if (rd_ok_ff) begin
               res_in.slot_valid       = 1'b1;
               res_in.out_key          = rd_ent.key;
               res_in.out_max_gap      = gap_ext[TIN_BITS-1:0];
               res_in.out_volume       = rd_ent.volume;
               res_in.out_weighted_sum = rd_ent.wsum;
               res_in.out_max_price    = rd_ent.max_price;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ENG_IDLE;
         fill_ff      <= '0;
         issue_ff     <= '0;
         chk_vld_ff   <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         issue_ff     <= issue_in;
         chk_vld_ff   <= chk_vld_in;
         res_valid_ff <= res_valid_in;
      end
      if (item_pop) begin
         it_ff   <= item;
         time_ff <= time_ext[TB-1:0];
      end
      prod_ff    <= {32'd0, it_ff.quantity} * {32'd0, it_ff.price};
      chk_idx_ff <= issue_ff[AW-1:0];
      rd_ok_ff   <= slot_ok;
      if (hit && (state_ff == ENG_SCAN)) begin
         ent_ff     <= rd_ent;
         hit_idx_ff <= chk_idx_ff;
      end
      res_ff <= res_in;
   end

   ptst_ram #(
      .WIDTH (EW),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_ent)),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign res_valid = res_valid_ff;
   assign res       = res_ff;

endmodule
`default_nettype wire

[tb/tb_per_key_trade_stats_table_unit.sv]
`default_nettype none
module tb_per_key_trade_stats_table_unit;
   import ptst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // The worst case for an item is a full scan of the table plus long idles
   // on both sides. The limit on the whole run leaves a wide margin over that.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int KEY_POOL    = 72;   // more keys than slots, so the table fills

   // Mirror of the statistics table. It tracks every entry the block holds
   // and queues the result that each accepted item must produce.
   class trade_table_scoreboard;
      bit                    used[64];
      logic [KEY_BITS-1:0]   sym[64];
      logic [TIN_BITS-1:0]   last_time[64];
      logic [TIN_BITS-1:0]   widest_gap[64];
      logic [VOL_BITS-1:0]   volume[64];
      logic [PRICE_BITS-1:0] top_price[64];
      logic [SUM_BITS-1:0]   notional[64];
      int                    fill;
      result_type            pending[$];

      function void show_entry(ref result_type r, input int s);
         r.slot_valid       = 1'b1;
         r.out_key          = sym[s];
         r.out_max_gap      = widest_gap[s];
         r.out_volume       = volume[s];
         r.out_weighted_sum = notional[s];
         r.out_max_price    = top_price[s];
         r.out_slot         = SLOT_BITS'(s);
      endfunction

      function void note_request(bit is_read, logic [63:0] key, logic [39:0] t,
                                 logic [31:0] qty, logic [31:0] price,
                                 logic [5:0] rslot);
         result_type r;
         int hit;
         logic [63:0] prod;
         logic [48:0] vsum;
         logic [39:0] gap;
         r = '0;
         hit = -1;
         prod = 64'(qty) * 64'(price);
         if (is_read) begin
            r.status = STATUS_READ;
            r.out_slot = rslot;
            if (used[rslot]) show_entry(r, rslot);
         end else begin
            for (int i = 0; i < 64; i++)
               if (hit < 0 && used[i] && sym[i] == key) hit = i;
            if (hit >= 0) begin
               // Gap wraps modulo the time width, so a clock going backwards
               // shows up as a very large gap.
               gap = t - last_time[hit];
               vsum = 49'(volume[hit]) + 49'(qty);
               volume[hit] = vsum[48] ? '1 : vsum[47:0];
               if (price > top_price[hit]) top_price[hit] = price;
               if (gap > widest_gap[hit]) widest_gap[hit] = gap;
               last_time[hit] = t;
               notional[hit] = notional[hit] + prod;
               r.status = STATUS_UPDATED;
               show_entry(r, hit);
            end else if (fill >= 64) begin
               r.status = STATUS_FULL;
            end else begin
               used[fill] = 1'b1;
               sym[fill] = key;
               last_time[fill] = t;
               widest_gap[fill] = '0;
               volume[fill] = 48'(qty);
               top_price[fill] = price;
               notional[fill] = prod;
               r.status = STATUS_INSERTED;
               show_entry(r, fill);
               fill++;
            end
         end
         pending = {pending, r};
      endfunction

      // Returns an empty string on a match, else a description of the fault.
      function string check_result(logic [1:0] st, logic [RSP_DATA_BITS-1:0] d);
         result_type e;
         string msg;
         msg = "";
         if (pending.size() == 0) return "result arrived with nothing expected";
         e = pending.pop_front();
         if (st != e.status)
            msg = {msg, $sformatf(" status %0d/%0d", st, e.status)};
         if (d[0] != e.slot_valid)
            msg = {msg, $sformatf(" slot_valid %0d/%0d", d[0], e.slot_valid)};
         if (d[64:1] != e.out_key)
            msg = {msg, $sformatf(" key %h/%h", d[64:1], e.out_key)};
         if (d[104:65] != e.out_max_gap)
            msg = {msg, $sformatf(" max_gap %h/%h", d[104:65], e.out_max_gap)};
         if (d[152:105] != e.out_volume)
            msg = {msg, $sformatf(" volume %h/%h", d[152:105], e.out_volume)};
         if (d[216:153] != e.out_weighted_sum)
            msg = {msg, $sformatf(" wsum %h/%h", d[216:153], e.out_weighted_sum)};
         if (d[248:217] != e.out_max_price)
            msg = {msg, $sformatf(" max_price %h/%h", d[248:217], e.out_max_price)};
         if (d[254:249] != e.out_slot)
            msg = {msg, $sformatf(" slot %0d/%0d", d[254:249], e.out_slot)};
         if (d[255] != 1'b0)
            msg = {msg, " padding bit set"};
         return msg;
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;
   logic                     req_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [1:0]               rsp_tuser;

   trade_table_scoreboard stats_sb;
   int  mismatches;
   int  cycles;
   bit  hurry;                 // when set, neither side inserts idle cycles
   logic [63:0] key_pool[KEY_POOL];

   per_key_trade_stats_table_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Cycle watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch:%s", $realtime, what);
   endtask

   // Idle length: mostly none or short, now and then a long pause.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (hurry || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Result side: the ready line toggles in runs, which holds results in the output
   // register and backs up the queue. Each accepted transfer is checked at the rising edge.
   initial begin
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         int n;
         n = pick_gap();
         rsp_tready = 1'b0;
         repeat (n) @(negedge clock);
         rsp_tready = 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         string m;
         m = stats_sb.check_result(rsp_tuser, rsp_tdata);
         if (m != "") report_mismatch(m);
      end
   end

   // Sends one item and returns once the transfer has taken place. Called at
   // a falling edge; returns at the falling edge after the transfer with valid held,
   // so back-to-back calls keep the stream dense.
   task automatic send_item(input bit is_read, input logic [63:0] key,
                            input logic [39:0] t, input logic [31:0] qty,
                            input logic [31:0] price, input logic [5:0] rslot);
      int n;
      n = pick_gap();
      if (n > 0) begin
         req_tvalid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = is_read;
      req_tdata  = {2'b00, rslot, price, qty, t, key};
      do @(posedge clock); while (!req_tready);
      stats_sb.note_request(is_read, key, t, qty, price, rslot);
      @(negedge clock);
   endtask

   task automatic send_trade(input logic [63:0] key, input logic [39:0] t,
                             input logic [31:0] qty, input logic [31:0] price);
      send_item(1'b0, key, t, qty, price, 6'($urandom));
   endtask

   task automatic send_read(input logic [5:0] rslot);
      send_item(1'b1, {$urandom, $urandom}, 40'({$urandom, $urandom}), $urandom,
                $urandom, rslot);
   endtask

   initial begin
      logic [39:0] clk_ticks;
      logic [63:0] k;
      stats_sb   = new();
      mismatches = 0;
      cycles     = 0;
      hurry      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = 1'b0;
      req_tdata  = '0;
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      key_pool[2] = 64'h0000_4C50_4141_0000;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty reads, extreme fields, wrapped and backward gaps.
      send_read(6'd0);
      send_read(6'd63);
      send_trade(64'h0, '1, '1, '1);
      send_trade('1, '0, '0, '0);
      send_trade(64'h0, 40'd0, 32'd1, 32'd0);           // time wraps: gap of one
      send_trade(64'h0, 40'd100, '1, '1);
      send_trade(64'h0, 40'd50, 32'd7, 32'd9);          // time goes backwards
      send_read(6'd0);
      send_read(6'd1);
      send_read(6'd2);
      send_trade(64'h0000_4C50_4141_0000, 40'h80_0000_0000, 32'h8000_0000,
                 32'h8000_0000);
      send_read(6'd2);

      // Dense burst of maximum quantities on the all-ones key in slot 1.
      hurry = 1'b1;
      clk_ticks = '0;
      for (int i = 0; i < 40; i++) begin
         clk_ticks += 40'($urandom_range(1, 1000));
         send_trade('1, clk_ticks, '1, 32'($urandom));
      end
      hurry = 1'b0;
      send_read(6'd1);

      // Random traffic: keys from a pool larger than the table, so it fills
      // and later new keys are dropped. Reads spread over every slot.
      clk_ticks = 40'({$urandom, $urandom});
      for (int i = 0; i < 750; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_read(6'($urandom));
         end else begin
            k = key_pool[$urandom_range(0, KEY_POOL - 1)];
            if ($urandom_range(0, 9) == 0) clk_ticks = 40'({$urandom, $urandom});
            else clk_ticks += 40'($urandom_range(0, 5000));
            send_trade(k, clk_ticks, $urandom_range(0, 3) == 0 ? $urandom
                       : 32'($urandom_range(0, 1000)), $urandom);
         end
      end
      req_tvalid = 1'b0;

      while (stats_sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Anything still expected at the end is caught above by the drain loop;
   // a stuck block instead runs into the watchdog.
endmodule
`default_nettype wire

[files.f]
rtl/ptst_pkg.sv
rtl/ptst_ram.sv
rtl/ptst_front.sv
rtl/ptst_engine.sv
rtl/per_key_trade_stats_table_unit.sv
tb/tb_per_key_trade_stats_table_unit.sv
